/* hw/rtl/diffie_hellman_key_agreement_top_assert.svh */
// Assertion macros shared by the key agreement RTL.
`ifndef DIFFIE_HELLMAN_KEY_AGREEMENT_TOP_ASSERT_SVH
`define DIFFIE_HELLMAN_KEY_AGREEMENT_TOP_ASSERT_SVH

// Same-cycle implication under an active-low asynchronous reset.
`define DH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dh assertion failed");

// Next-cycle implication under an active-low asynchronous reset.
`define DH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dh assertion failed");

`endif

/* hw/rtl/dh_pkg.sv */
// Shared types, constants and command/status structs for the key agreement block.
package dh_pkg;

	localparam int WORD_BITS = 32;
	localparam int CNT_W     = $clog2(WORD_BITS);
	localparam int CFG_IDX_W = 1;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam word_t MODULUS_RESET   = WORD_BITS'(23);
	localparam word_t GENERATOR_RESET = WORD_BITS'(5);

	localparam cfg_idx_t REG_MODULUS   = CFG_IDX_W'(0);
	localparam cfg_idx_t REG_GENERATOR = CFG_IDX_W'(1);

	typedef struct packed {
		word_t private_exponent;
		word_t peer_public;
	} in_t;

	typedef struct packed {
		word_t own_public;
		word_t shared_secret;
		logic  params_bad;
	} out_t;

	// Which modular product the shared multiplier works on.
	typedef enum logic [1:0] {
		OP_PUB,
		OP_SHR,
		OP_SQG,
		OP_SQP
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_OP_START,
		ST_OP_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic rem_step;
		logic mul_start;
		logic mul_write;
		logic result_load;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic params_bad;
		logic exp_bit;
		logic last_bit;
		logic mul_done;
	} sts_t;

endpackage

/* hw/rtl/diffie_hellman_key_agreement_top.sv */
// Top level of the Diffie-Hellman key agreement block: controller plus datapath.
//
//  channel | direction | handshake               | beat contents
//  --------+-----------+-------------------------+-----------------------------------------
//  in      | input     | in_valid / in_ready     | private_exponent, peer_public
//  out     | output    | out_valid / out_ready   | own_public, shared_secret, params_bad
//  cfg     | input     | cfg_write (no wait)     | cfg_index (0 modulus, 1 generator), cfg_data
//
// One item is worked at a time. For each of the 32 exponent bits the single shared serial
// modular multiplier forms the products with the two accumulators, skipped where the bit
// is clear, and the squares of the generator and peer powers; before that a restoring
// reduction brings the peer value below the modulus.
// A bad modulus or generator skips reduction and ladder; the result then has params_bad set.
// Reset brings the modulus to 23, the generator to 5 and clears out_valid (not result data).
// A finished result holds in the output register while the next input beat is taken;
// the block stalls in its final step only if that register is still full.
module diffie_hellman_key_agreement_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dh_pkg::in_t      in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output dh_pkg::out_t     out_data,
	input  logic             cfg_write,
	input  dh_pkg::cfg_idx_t cfg_index,
	input  dh_pkg::word_t    cfg_data
);
	import dh_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequence the reduction and the square-and-multiply ladder; own both handshakes.
	dh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold config, working values and the result register; config changes on cfg_write, the rest on commands only.
	dh_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

/* hw/rtl/dh_modmul.sv */
// Serial modular multiplier: one multiplier bit per cycle by shift-and-add.
module dh_modmul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  dh_pkg::word_t a,
	input  dh_pkg::word_t b,
	input  dh_pkg::word_t m,
	output logic          done,
	output dh_pkg::word_t product
);
	import dh_pkg::*;

	word_t a_q;
	word_t b_q;
	word_t acc_q;
	cnt_t  cnt_q;
	logic  busy_q;
	logic  done_q;

	// (x + y) mod m for x, y below m.
	function automatic word_t add_mod(word_t x, word_t y, word_t mm);
		logic [WORD_BITS:0] sum;
		sum = {1'b0, x} + {1'b0, y};
		if (sum >= {1'b0, mm}) begin
			sum = sum - {1'b0, mm};
		end
		return sum[WORD_BITS-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= add_mod(acc_q, a_q, m);
			end
			a_q <= add_mod(a_q, a_q, m);
			b_q <= b_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

/* hw/rtl/dh_datapath.sv */
// Datapath: config registers, peer reduction, exponentiation state and result register.
module dh_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  dh_pkg::cfg_idx_t cfg_index,
	input  dh_pkg::word_t    cfg_data,
	input  dh_pkg::in_t      in_data,
	input  dh_pkg::cmd_t     cmd,
	output dh_pkg::sts_t     sts,
	output dh_pkg::out_t     out_data
);
	import dh_pkg::*;

	word_t mod_q;
	word_t gen_q;
	word_t pub_q;
	word_t shr_q;
	word_t gpow_q;
	word_t ppow_q;
	word_t exp_q;
	word_t peer_sh_q;
	word_t rem_q;
	cnt_t  bit_cnt_q;
	logic  bad_q;
	out_t  res_q;

	word_t              mul_a;
	word_t              mul_b;
	word_t              product;
	logic               mul_done;
	logic [WORD_BITS:0] rem_shift;
	word_t              rem_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MODULUS_RESET;
			gen_q <= GENERATOR_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MODULUS:   mod_q <= cfg_data;
				REG_GENERATOR: gen_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Restoring remainder step: bring in the next peer bit, subtract once.
	always_comb begin
		rem_shift = {rem_q, peer_sh_q[WORD_BITS-1]};
		if (rem_shift >= {1'b0, mod_q}) begin
			rem_shift = rem_shift - {1'b0, mod_q};
		end
		rem_next = rem_shift[WORD_BITS-1:0];
	end

	always_comb begin
		case (cmd.op)
			OP_PUB: begin
				mul_a = pub_q;
				mul_b = gpow_q;
			end
			OP_SHR: begin
				mul_a = shr_q;
				mul_b = ppow_q;
			end
			OP_SQG: begin
				mul_a = gpow_q;
				mul_b = gpow_q;
			end
			default: begin
				mul_a = ppow_q;
				mul_b = ppow_q;
			end
		endcase
	end

	dh_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.m       (mod_q),
		.done    (mul_done),
		.product (product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
		end else if (cmd.load) begin
			bit_cnt_q <= '0;
		end else if (cmd.rem_step || (cmd.mul_write && cmd.op == OP_SQP)) begin
			bit_cnt_q <= bit_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pub_q     <= WORD_BITS'(1);
			shr_q     <= WORD_BITS'(1);
			gpow_q    <= gen_q;
			exp_q     <= in_data.private_exponent;
			peer_sh_q <= in_data.peer_public;
			rem_q     <= '0;
			bad_q     <= sts.params_bad;
		end
		if (cmd.rem_step) begin
			rem_q     <= rem_next;
			peer_sh_q <= peer_sh_q << 1;
			if (bit_cnt_q == CNT_W'(WORD_BITS - 1)) begin
				ppow_q <= rem_next;
			end
		end
		if (cmd.mul_write) begin
			case (cmd.op)
				OP_PUB: pub_q  <= product;
				OP_SHR: shr_q  <= product;
				OP_SQG: gpow_q <= product;
				default: begin
					ppow_q <= product;
					exp_q  <= exp_q >> 1;
				end
			endcase
		end
		if (cmd.result_load) begin
			if (bad_q) begin
				res_q.own_public    <= '0;
				res_q.shared_secret <= '0;
				res_q.params_bad    <= 1'b1;
			end else begin
				res_q.own_public    <= pub_q;
				res_q.shared_secret <= shr_q;
				res_q.params_bad    <= 1'b0;
			end
		end
	end

	assign sts.params_bad = (mod_q < WORD_BITS'(2)) || (gen_q >= mod_q);
	assign sts.exp_bit    = exp_q[0];
	assign sts.last_bit   = (bit_cnt_q == CNT_W'(WORD_BITS - 1));
	assign sts.mul_done   = mul_done;
	assign out_data       = res_q;

endmodule

/* hw/rtl/dh_ctrl.sv */
// Controller: sequences reduction, products and squarings, and owns the handshakes.
`include "diffie_hellman_key_agreement_top_assert.svh"

module dh_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  dh_pkg::sts_t sts,
	output dh_pkg::cmd_t cmd
);
	import dh_pkg::*;

	state_t state_q;
	state_t state_d;
	op_t    op_q;
	op_t    op_d;
	logic   out_valid_q;
	logic   skip;
	logic   out_free;

	function automatic op_t next_op(op_t op);
		unique case (op)
			OP_PUB:  return OP_SHR;
			OP_SHR:  return OP_SQG;
			OP_SQG:  return OP_SQP;
			default: return OP_PUB;
		endcase
	endfunction

	// Drop the accumulator products when the current exponent bit is clear.
	assign skip     = (op_q == OP_PUB || op_q == OP_SHR) && !sts.exp_bit;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.params_bad ? ST_FINISH : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (sts.last_bit) begin
					state_d = ST_OP_START;
					op_d    = OP_PUB;
				end
			end
			ST_OP_START: begin
				if (skip) begin
					op_d = next_op(op_q);
				end else begin
					state_d = ST_OP_WAIT;
				end
			end
			ST_OP_WAIT: begin
				if (sts.mul_done) begin
					op_d = next_op(op_q);
					if (op_q == OP_SQP && sts.last_bit) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_OP_START;
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load        = (state_q == ST_IDLE) && in_valid;
		cmd.rem_step    = (state_q == ST_REDUCE);
		cmd.mul_start   = (state_q == ST_OP_START) && !skip;
		cmd.mul_write   = (state_q == ST_OP_WAIT) && sts.mul_done;
		cmd.result_load = (state_q == ST_FINISH) && out_free;
		cmd.op          = op_q;
		in_ready        = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_PUB;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`DH_ASSERT_NOW(a_no_result_overwrite, clk, arst_n, cmd.result_load, !out_valid_q || out_ready)
	`DH_ASSERT_NOW(a_done_only_waiting, clk, arst_n, sts.mul_done, state_q == ST_OP_WAIT)
	`DH_ASSERT_NEXT(a_bad_params_skip, clk, arst_n, in_valid && in_ready && sts.params_bad, state_q == ST_FINISH)
	`DH_ASSERT_NEXT(a_start_then_wait, clk, arst_n, cmd.mul_start, state_q == ST_OP_WAIT && !sts.mul_done)

endmodule
